// File: src/bti_pkg.sv
package bti_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 65;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // one request to the shared add/subtract unit
    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

// File: src/breakpoint_table_interpolator.sv
// Piecewise-linear breakpoint table, signed Q16.16 keys and values.
// Request channel (req_valid/req_stall): operation 0 writes entry_key and
// entry_value at entry_index and gives no response; operation 1
// looks up lookup_key and gives one response on the rsp channel.
// A lookup reads the first entry, then the last (clamping), then scans the
// segments from the low end, each entry read through the table
// RAM port. Inside a segment one shared 65-bit adder does a 32-step
// shift-add multiply, a 64-step restoring divide and the final add.
// The block takes no new request while a lookup is running; writes
// are accepted back to back.
// The response sits in an output register; if rsp_stall holds it, a
// following lookup finishes and waits until that register frees up.
// cfg_wr_data sets the number of entries in use (0 reads as 1, values
// above TABLE_DEPTH read as TABLE_DEPTH); write it only while idle.
// Reset sets entries in use to 1 and clears the control state; table
// contents are undefined until written.
module breakpoint_table_interpolator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                operation,
    input  logic [5:0]                          entry_index,
    input  logic signed [bti_pkg::DATA_W-1:0]   entry_key,
    input  logic signed [bti_pkg::DATA_W-1:0]   entry_value,
    input  logic signed [bti_pkg::DATA_W-1:0]   lookup_key,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [bti_pkg::DATA_W-1:0]   interpolated_value,
    input  logic                                cfg_wr_en,
    input  logic [6:0]                          cfg_wr_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = (AW > 6) ? AW : 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_LAST  = 2'd1;
    localparam logic [1:0] PH_SCAN  = 2'd2;

    logic [2:0]                         state_reg, state_next;
    logic [1:0]                         phase_reg, phase_next;
    logic [AW-1:0]                      idx_reg, idx_next;
    logic [5:0]                         step_reg, step_next;
    logic [6:0]                         entries_in_use_reg;
    logic signed [bti_pkg::DATA_W-1:0]  x_reg, x_next;
    logic signed [bti_pkg::DATA_W-1:0]  klo_reg, klo_next;
    logic signed [bti_pkg::DATA_W-1:0]  vlo_reg, vlo_next;
    logic signed [bti_pkg::DATA_W-1:0]  vlast_reg, vlast_next;
    logic signed [bti_pkg::DATA_W-1:0]  res_reg, res_next;
    logic [31:0]                        dx_reg, dx_next;
    logic [31:0]                        dk_reg, dk_next;
    logic [32:0]                        mag_reg, mag_next;
    logic                               neg_reg, neg_next;
    logic [63:0]                        prod_reg, prod_next;
    logic [31:0]                        rem_reg, rem_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    logic signed [bti_pkg::DATA_W-1:0]  rsp_data_reg, rsp_data_next;

    logic [31:0]                        n_eff;
    logic [31:0]                        n_minus_1;
    logic [AW-1:0]                      last_idx;
    logic [IW-1:0]                      idx_wide;
    logic                               wr_en;
    logic                               req_accept;
    logic                               out_free;
    logic signed [bti_pkg::DATA_W-1:0]  rd_key;
    logic signed [bti_pkg::DATA_W-1:0]  rd_value;
    logic signed [32:0]                 dv;
    logic signed [32:0]                 dx_full;
    logic signed [32:0]                 dk_full;
    bti_pkg::alu_req_t                  alu_req;
    logic [bti_pkg::ACC_W-1:0]          alu_sum;
    logic signed [bti_pkg::ACC_W-1:0]   fin_sum;

    assign req_stall          = (state_reg != S_IDLE);
    assign req_accept         = req_valid && !req_stall;
    assign rsp_valid          = rsp_valid_reg;
    assign interpolated_value = rsp_data_reg;
    assign out_free           = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        priority if (entries_in_use_reg == 7'd0)
            n_eff = 32'd1;
        else if (32'(entries_in_use_reg) > TABLE_DEPTH)
            n_eff = 32'(TABLE_DEPTH);
        else
            n_eff = 32'(entries_in_use_reg);
    end

    assign n_minus_1 = n_eff - 32'd1;
    assign last_idx  = n_minus_1[AW-1:0];

    // writes beyond the table depth are dropped
    assign idx_wide = IW'(entry_index);
    assign wr_en    = req_accept && (operation == bti_pkg::OP_WRITE)
                      && (32'(entry_index) < TABLE_DEPTH);

    bti_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk          (clk),
        .wr_en        (wr_en),
        .wr_addr      (idx_wide[AW-1:0]),
        .wr_key       (entry_key),
        .wr_value     (entry_value),
        .rd_addr      (idx_reg),
        .rd_key_reg   (rd_key),
        .rd_value_reg (rd_value)
    );

    bti_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign fin_sum = alu_sum;
    assign dv      = 33'(rd_value) - 33'(vlo_reg);
    assign dx_full = 33'(x_reg) - 33'(klo_reg);
    assign dk_full = 33'(rd_key) - 33'(klo_reg);

    always_comb
    begin
        unique case (state_reg)
            S_MUL:
            begin
                alu_req.a   = {1'b0, prod_reg[62:0], 1'b0};
                alu_req.b   = dx_reg[31] ? bti_pkg::ACC_W'(mag_reg) : '0;
                alu_req.sub = 1'b0;
            end
            S_DIV:
            begin
                alu_req.a   = bti_pkg::ACC_W'({rem_reg, prod_reg[63]});
                alu_req.b   = bti_pkg::ACC_W'(dk_reg);
                alu_req.sub = 1'b1;
            end
            default:
            begin
                // quotient is below |dv| so 33 bits carry it
                alu_req.a   = bti_pkg::ACC_W'(vlo_reg);
                alu_req.b   = bti_pkg::ACC_W'(prod_reg[32:0]);
                alu_req.sub = neg_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        x_next         = x_reg;
        klo_next       = klo_reg;
        vlo_next       = vlo_reg;
        vlast_next     = vlast_reg;
        res_next       = res_reg;
        dx_next        = dx_reg;
        dk_next        = dk_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept && (operation == bti_pkg::OP_LOOKUP))
                begin
                    x_next     = lookup_key;
                    idx_next   = '0;
                    phase_next = PH_FIRST;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        if (x_reg < rd_key)
                        begin
                            res_next   = rd_value;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next   = last_idx;
                            phase_next = PH_LAST;
                            state_next = S_FETCH;
                        end
                    end
                    PH_LAST:
                    begin
                        if (x_reg >= rd_key)
                        begin
                            res_next   = rd_value;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            vlast_next = rd_value;
                            idx_next   = '0;
                            phase_next = PH_SCAN;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        priority if (idx_reg == '0)
                        begin
                            klo_next   = rd_key;
                            vlo_next   = rd_value;
                            idx_next   = idx_reg + AW'(1);
                            state_next = S_FETCH;
                        end
                        else if ((x_reg >= klo_reg) && (x_reg < rd_key))
                        begin
                            dx_next    = dx_full[31:0];
                            dk_next    = dk_full[31:0];
                            neg_next   = dv[32];
                            mag_next   = dv[32] ? 33'(-dv) : 33'(dv);
                            prod_next  = '0;
                            step_next  = '0;
                            state_next = S_MUL;
                        end
                        else if (idx_reg == last_idx)
                        begin
                            // no segment matched (keys out of order)
                            res_next   = vlast_reg;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            klo_next   = rd_key;
                            vlo_next   = rd_value;
                            idx_next   = idx_reg + AW'(1);
                            state_next = S_FETCH;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                prod_next = alu_sum[63:0];
                dx_next   = {dx_reg[30:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31)
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!alu_sum[bti_pkg::ACC_W-1])
                begin
                    rem_next  = alu_sum[31:0];
                    prod_next = {prod_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next  = {rem_reg[30:0], prod_reg[63]};
                    prod_next = {prod_reg[62:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                priority if (fin_sum > bti_pkg::ACC_W'(32'sh7FFF_FFFF))
                    res_next = 32'sh7FFF_FFFF;
                else if (fin_sum < -(bti_pkg::ACC_W'(33'sh0_8000_0000)))
                    res_next = -32'sh7FFF_FFFF - 32'sd1;
                else
                    res_next = fin_sum[31:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            phase_reg          <= PH_FIRST;
            rsp_valid_reg      <= 1'b0;
            entries_in_use_reg <= 7'd1;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
                entries_in_use_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        x_reg        <= x_next;
        klo_reg      <= klo_next;
        vlo_reg      <= vlo_next;
        vlast_reg    <= vlast_next;
        res_reg      <= res_next;
        dx_reg       <= dx_next;
        dk_reg       <= dk_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// File: src/bti_alu.sv
module bti_alu (
    input  bti_pkg::alu_req_t           req,
    output logic [bti_pkg::ACC_W-1:0]   sum
);

    logic [bti_pkg::ACC_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = req.a + b_op + bti_pkg::ACC_W'(req.sub);

endmodule

// File: src/bti_store.sv
module bti_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [bti_pkg::DATA_W-1:0]   wr_key,
    input  logic signed [bti_pkg::DATA_W-1:0]   wr_value,
    input  logic [AW-1:0]                       rd_addr,
    output logic signed [bti_pkg::DATA_W-1:0]   rd_key_reg,
    output logic signed [bti_pkg::DATA_W-1:0]   rd_value_reg
);

    logic signed [bti_pkg::DATA_W-1:0] key_mem   [DEPTH];
    logic signed [bti_pkg::DATA_W-1:0] value_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

endmodule
